/* design/nnis_pkg.sv */
package nnis_pkg;

    localparam int POS_W       = 12;
    localparam int CHAN_W      = 16;
    localparam int SRC_DIM_W   = 9;
    localparam int BOX_DIM_W   = 13;
    localparam int CFG_DATA_W  = 13;
    localparam int CFG_INDEX_W = 2;

    localparam logic [SRC_DIM_W-1:0] SRC_DIM_RESET = 9'd256;
    localparam logic [BOX_DIM_W-1:0] BOX_DIM_RESET = 13'd256;

    typedef enum logic [CFG_INDEX_W-1:0] {
        CFG_SRC_WIDTH  = 2'd0,
        CFG_SRC_HEIGHT = 2'd1,
        CFG_BOX_WIDTH  = 2'd2,
        CFG_BOX_HEIGHT = 2'd3
    } cfg_index_t;

    typedef enum logic {
        REQ_LOAD = 1'b0,
        REQ_READ = 1'b1
    } req_type_t;

    typedef struct packed {
        logic [CHAN_W-1:0] hue;
        logic [CHAN_W-1:0] sat;
        logic [CHAN_W-1:0] lum;
        logic [CHAN_W-1:0] alpha;
    } pixel_t;

endpackage

/* design/nnis_if.sv */
interface nnis_req_if;
    logic                       valid;
    logic                       ready;
    logic                       req_type;
    logic [nnis_pkg::POS_W-1:0]  pos_x;
    logic [nnis_pkg::POS_W-1:0]  pos_y;
    logic [nnis_pkg::CHAN_W-1:0] in_hue;
    logic [nnis_pkg::CHAN_W-1:0] in_sat;
    logic [nnis_pkg::CHAN_W-1:0] in_lum;
    logic [nnis_pkg::CHAN_W-1:0] in_alpha;

    modport source (
        output valid, req_type, pos_x, pos_y, in_hue, in_sat, in_lum, in_alpha,
        input  ready
    );

    modport sink (
        input  valid, req_type, pos_x, pos_y, in_hue, in_sat, in_lum, in_alpha,
        output ready
    );
endinterface

interface nnis_rsp_if;
    logic                          valid;
    logic                          ready;
    logic [nnis_pkg::CHAN_W-1:0]    out_hue;
    logic [nnis_pkg::CHAN_W-1:0]    out_sat;
    logic [nnis_pkg::CHAN_W-1:0]    out_lum;
    logic [nnis_pkg::CHAN_W-1:0]    out_alpha;
    logic [nnis_pkg::BOX_DIM_W-1:0] out_width;
    logic [nnis_pkg::BOX_DIM_W-1:0] out_height;
    logic                          out_of_range;

    modport source (
        output valid, out_hue, out_sat, out_lum, out_alpha, out_width, out_height,
               out_of_range,
        input  ready
    );

    modport sink (
        input  valid, out_hue, out_sat, out_lum, out_alpha, out_width, out_height,
               out_of_range,
        output ready
    );
endinterface

/* design/nnis_mul.sv */
module nnis_mul #(
    parameter int A_W = 13,
    parameter int B_W = 9
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    input  logic [A_W-1:0]     a,
    input  logic [B_W-1:0]     b,
    output logic               done,
    output logic [A_W+B_W-1:0] product
);

    localparam int CNT_W = $clog2(B_W + 1);

    logic               busy_reg, busy_next;
    logic               done_reg, done_next;
    logic [CNT_W-1:0]   count_reg, count_next;
    logic [A_W+B_W-1:0] prod_reg, prod_next;
    logic [A_W-1:0]     a_reg, a_next;
    logic [A_W:0]       sum;

    always_comb
    begin
        sum        = {1'b0, prod_reg[A_W+B_W-1:B_W]} + {1'b0, a_reg & {A_W{prod_reg[0]}}};
        busy_next  = busy_reg;
        done_next  = 1'b0;
        count_next = count_reg;
        prod_next  = prod_reg;
        a_next     = a_reg;
        if (start)
        begin
            busy_next  = 1'b1;
            count_next = '0;
            prod_next  = {{A_W{1'b0}}, b};
            a_next     = a;
        end
        else if (busy_reg)
        begin
            // add one multiplier bit, shift right
            prod_next  = {sum, prod_reg[B_W-1:1]};
            count_next = count_reg + CNT_W'(1);
            if (count_reg == CNT_W'(B_W - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg  <= 1'b0;
            done_reg  <= 1'b0;
            count_reg <= '0;
        end
        else
        begin
            busy_reg  <= busy_next;
            done_reg  <= done_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        prod_reg <= prod_next;
        a_reg    <= a_next;
    end

    assign done    = done_reg;
    assign product = prod_reg;

endmodule

/* design/nnis_div.sv */
module nnis_div #(
    parameter int N_W = 22,
    parameter int D_W = 13,
    parameter int Q_W = 13
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           start,
    input  logic [N_W-1:0] dividend,
    input  logic [D_W-1:0] divisor,
    output logic           done,
    output logic [Q_W-1:0] quotient
);

    localparam int CNT_W = $clog2(Q_W + 1);

    logic             busy_reg, busy_next;
    logic             done_reg, done_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic [D_W-1:0]   rem_reg, rem_next;
    logic [Q_W-1:0]   shift_reg, shift_next;
    logic [D_W-1:0]   dvs_reg, dvs_next;
    logic [D_W:0]     trial;
    logic [D_W:0]     diff;
    logic             fits;

    always_comb
    begin
        trial      = {rem_reg, shift_reg[Q_W-1]};
        diff       = trial - {1'b0, dvs_reg};
        fits       = (trial >= {1'b0, dvs_reg});
        busy_next  = busy_reg;
        done_next  = 1'b0;
        count_next = count_reg;
        rem_next   = rem_reg;
        shift_next = shift_reg;
        dvs_next   = dvs_reg;
        if (start)
        begin
            busy_next  = 1'b1;
            count_next = '0;
            rem_next   = D_W'(dividend >> Q_W);
            shift_next = dividend[Q_W-1:0];
            dvs_next   = divisor;
        end
        else if (busy_reg)
        begin
            // one quotient bit per step, restoring
            rem_next   = fits ? diff[D_W-1:0] : trial[D_W-1:0];
            shift_next = {shift_reg[Q_W-2:0], fits};
            count_next = count_reg + CNT_W'(1);
            if (count_reg == CNT_W'(Q_W - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg  <= 1'b0;
            done_reg  <= 1'b0;
            count_reg <= '0;
        end
        else
        begin
            busy_reg  <= busy_next;
            done_reg  <= done_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg   <= rem_next;
        shift_reg <= shift_next;
        dvs_reg   <= dvs_next;
    end

    assign done     = done_reg;
    assign quotient = shift_reg;

endmodule

/* design/nearest_neighbor_image_scaler.sv */
// Nearest-neighbour scaler that fits a source image of up to MAX_SRC_DIM square into a
// target box while keeping the aspect ratio. A load request writes one HSLA pixel into the
// on-chip frame store and returns nothing unless it falls outside the source, in which case
// a flagged result comes back. A read request returns the source pixel nearest to the given
// output coordinate together with the computed output size, or a flagged result if the
// coordinate lies outside that size. All multiplies and divides run on one shared shift-add
// multiplier (9 steps) and one restoring divider (13 steps): a load takes one multiply, a
// read three multiplies and two divides in a row, and requests are handled one at a time.
// After reset and after every configuration write the output size is recomputed with two
// multiplies and one divide, during which no request is taken. The frame store holds no
// defined data until loaded.
module nearest_neighbor_image_scaler #(
    parameter int MAX_SRC_DIM = 256,
    parameter int MAX_OUT_DIM = 4096
) (
    input  logic                              clk,
    input  logic                              rst_n,
    nnis_req_if.sink                          request,
    nnis_rsp_if.source                        result,
    input  logic                              cfg_write,
    input  logic [nnis_pkg::CFG_INDEX_W-1:0]  cfg_index,
    input  logic [nnis_pkg::CFG_DATA_W-1:0]   cfg_data
);

    localparam int SRC_W    = nnis_pkg::SRC_DIM_W;
    localparam int BOX_W    = nnis_pkg::BOX_DIM_W;
    localparam int POS_W    = nnis_pkg::POS_W;
    localparam int PROD_W   = BOX_W + SRC_W;
    localparam int SRC_CODE = (1 << SRC_W) - 1;
    localparam int BOX_CODE = (1 << BOX_W) - 1;
    localparam int SRC_CAP  = (MAX_SRC_DIM < SRC_CODE) ? MAX_SRC_DIM : SRC_CODE;
    localparam int BOX_CAP  = (MAX_OUT_DIM < BOX_CODE) ? MAX_OUT_DIM : BOX_CODE;
    localparam int STORE_DEPTH = MAX_SRC_DIM * MAX_SRC_DIM;
    localparam int ADDR_W   = $clog2(STORE_DEPTH);

    localparam logic [SRC_W-1:0] SRC_CAP_V = SRC_W'(SRC_CAP);
    localparam logic [BOX_W-1:0] BOX_CAP_V = BOX_W'(BOX_CAP);

    typedef enum logic [12:0] {
        ST_IDLE         = 13'b0000000000001,
        ST_FIT_MUL_A    = 13'b0000000000010,
        ST_FIT_MUL_B    = 13'b0000000000100,
        ST_FIT_DIV      = 13'b0000000001000,
        ST_CHECK        = 13'b0000000010000,
        ST_LOAD_MUL     = 13'b0000000100000,
        ST_READ_MUL_X   = 13'b0000001000000,
        ST_READ_DIV_X   = 13'b0000010000000,
        ST_READ_MUL_Y   = 13'b0000100000000,
        ST_READ_DIV_Y   = 13'b0001000000000,
        ST_READ_MUL_IDX = 13'b0010000000000,
        ST_READ_MEM     = 13'b0100000000000,
        ST_EMIT         = 13'b1000000000000
    } state_t;

    state_t state_reg, state_next;
    logic   dirty_reg, dirty_next;
    logic   out_valid_reg, out_valid_next;

    logic [SRC_W-1:0] src_width_reg, src_height_reg;
    logic [BOX_W-1:0] box_width_reg, box_height_reg;
    logic [SRC_W-1:0] sw, sh;
    logic [BOX_W-1:0] bw, bh;

    logic [BOX_W-1:0]  ow_reg, ow_next;
    logic [BOX_W-1:0]  oh_reg, oh_next;
    logic [PROD_W-1:0] pa_reg, pa_next;
    logic              fit_h_reg, fit_h_next;
    logic [SRC_W-1:0]  sx_reg, sx_next;
    nnis_pkg::pixel_t  pix_reg, pix_next;
    logic              flag_reg, flag_next;
    nnis_pkg::pixel_t  out_pix_reg, out_pix_next;
    logic              out_flag_reg, out_flag_next;

    logic              req_type_reg;
    logic [POS_W-1:0]  px_reg, py_reg;
    nnis_pkg::pixel_t  load_pix_reg;
    logic              accept;

    logic              mul_start, mul_done;
    logic [BOX_W-1:0]  mul_a;
    logic [SRC_W-1:0]  mul_b;
    logic [PROD_W-1:0] mul_product;
    logic              div_start, div_done;
    logic [PROD_W-1:0] div_dividend;
    logic [BOX_W-1:0]  div_divisor;
    logic [BOX_W-1:0]  div_quotient;
    logic [BOX_W-1:0]  fit_q;

    logic [PROD_W:0]   idx_sum;
    logic [ADDR_W-1:0] mem_addr;
    logic              mem_we, mem_re;
    nnis_pkg::pixel_t  frame_store [STORE_DEPTH];
    nnis_pkg::pixel_t  mem_q_reg;

    nnis_mul #(
        .A_W (BOX_W),
        .B_W (SRC_W)
    ) u_mul (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (mul_start),
        .a       (mul_a),
        .b       (mul_b),
        .done    (mul_done),
        .product (mul_product)
    );

    nnis_div #(
        .N_W (PROD_W),
        .D_W (BOX_W),
        .Q_W (BOX_W)
    ) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (div_dividend),
        .divisor  (div_divisor),
        .done     (div_done),
        .quotient (div_quotient)
    );

    always_comb
    begin
        sw = (src_width_reg == '0) ? SRC_W'(1) :
             (src_width_reg > SRC_CAP_V) ? SRC_CAP_V : src_width_reg;
        sh = (src_height_reg == '0) ? SRC_W'(1) :
             (src_height_reg > SRC_CAP_V) ? SRC_CAP_V : src_height_reg;
        bw = (box_width_reg == '0) ? BOX_W'(1) :
             (box_width_reg > BOX_CAP_V) ? BOX_CAP_V : box_width_reg;
        bh = (box_height_reg == '0) ? BOX_W'(1) :
             (box_height_reg > BOX_CAP_V) ? BOX_CAP_V : box_height_reg;
    end

    assign request.ready = (state_reg == ST_IDLE) && !dirty_reg;
    assign accept        = request.valid && request.ready;

    assign fit_q    = (div_quotient == '0) ? BOX_W'(1) : div_quotient;
    assign idx_sum  = {1'b0, mul_product} +
                      ((state_reg == ST_LOAD_MUL) ? (PROD_W + 1)'(px_reg)
                                                  : (PROD_W + 1)'(sx_reg));
    assign mem_addr = idx_sum[ADDR_W-1:0];
    assign mem_we   = (state_reg == ST_LOAD_MUL) && mul_done;
    assign mem_re   = (state_reg == ST_READ_MUL_IDX) && mul_done;

    always_comb
    begin
        state_next     = state_reg;
        dirty_next     = dirty_reg;
        out_valid_next = out_valid_reg;
        ow_next        = ow_reg;
        oh_next        = oh_reg;
        pa_next        = pa_reg;
        fit_h_next     = fit_h_reg;
        sx_next        = sx_reg;
        pix_next       = pix_reg;
        flag_next      = flag_reg;
        out_pix_next   = out_pix_reg;
        out_flag_next  = out_flag_reg;
        mul_start      = 1'b0;
        mul_a          = bw;
        mul_b          = sh;
        div_start      = 1'b0;
        div_dividend   = mul_product;
        div_divisor    = ow_reg;

        if (out_valid_reg && result.ready)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            ST_IDLE:
            begin
                if (dirty_reg && !cfg_write)
                begin
                    mul_start  = 1'b1;
                    dirty_next = 1'b0;
                    state_next = ST_FIT_MUL_A;
                end
                else if (accept)
                begin
                    state_next = ST_CHECK;
                end
            end
            ST_FIT_MUL_A:
            begin
                if (mul_done)
                begin
                    pa_next    = mul_product;
                    mul_a      = bh;
                    mul_b      = sw;
                    mul_start  = 1'b1;
                    state_next = ST_FIT_MUL_B;
                end
            end
            ST_FIT_MUL_B:
            begin
                if (mul_done)
                begin
                    // height-bound when sh*bw exceeds bh*sw
                    fit_h_next   = (pa_reg > mul_product);
                    div_dividend = (pa_reg > mul_product) ? mul_product : pa_reg;
                    div_divisor  = (pa_reg > mul_product) ? BOX_W'(sh) : BOX_W'(sw);
                    div_start    = 1'b1;
                    state_next   = ST_FIT_DIV;
                end
            end
            ST_FIT_DIV:
            begin
                if (div_done)
                begin
                    ow_next    = fit_h_reg ? fit_q : bw;
                    oh_next    = fit_h_reg ? bh : fit_q;
                    state_next = ST_IDLE;
                end
            end
            ST_CHECK:
            begin
                if (req_type_reg == nnis_pkg::REQ_LOAD)
                begin
                    if ((px_reg < POS_W'(sw)) && (py_reg < POS_W'(sh)))
                    begin
                        mul_a      = BOX_W'(py_reg);
                        mul_b      = sw;
                        mul_start  = 1'b1;
                        state_next = ST_LOAD_MUL;
                    end
                    else
                    begin
                        pix_next   = '0;
                        flag_next  = 1'b1;
                        state_next = ST_EMIT;
                    end
                end
                else
                begin
                    if ((BOX_W'(px_reg) < ow_reg) && (BOX_W'(py_reg) < oh_reg))
                    begin
                        mul_a      = BOX_W'(px_reg);
                        mul_b      = sw;
                        mul_start  = 1'b1;
                        state_next = ST_READ_MUL_X;
                    end
                    else
                    begin
                        pix_next   = '0;
                        flag_next  = 1'b1;
                        state_next = ST_EMIT;
                    end
                end
            end
            ST_LOAD_MUL:
            begin
                if (mul_done)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_READ_MUL_X:
            begin
                if (mul_done)
                begin
                    div_divisor = ow_reg;
                    div_start   = 1'b1;
                    state_next  = ST_READ_DIV_X;
                end
            end
            ST_READ_DIV_X:
            begin
                if (div_done)
                begin
                    sx_next    = div_quotient[SRC_W-1:0];
                    mul_a      = BOX_W'(py_reg);
                    mul_b      = sh;
                    mul_start  = 1'b1;
                    state_next = ST_READ_MUL_Y;
                end
            end
            ST_READ_MUL_Y:
            begin
                if (mul_done)
                begin
                    div_divisor = oh_reg;
                    div_start   = 1'b1;
                    state_next  = ST_READ_DIV_Y;
                end
            end
            ST_READ_DIV_Y:
            begin
                if (div_done)
                begin
                    mul_a      = div_quotient;
                    mul_b      = sw;
                    mul_start  = 1'b1;
                    state_next = ST_READ_MUL_IDX;
                end
            end
            ST_READ_MUL_IDX:
            begin
                if (mul_done)
                begin
                    state_next = ST_READ_MEM;
                end
            end
            ST_READ_MEM:
            begin
                pix_next   = mem_q_reg;
                flag_next  = 1'b0;
                state_next = ST_EMIT;
            end
            ST_EMIT:
            begin
                // hold until the output register is free
                if (!out_valid_reg || result.ready)
                begin
                    out_pix_next   = pix_reg;
                    out_flag_next  = flag_reg;
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        if (cfg_write)
        begin
            dirty_next = 1'b1;
            // drop a size computation in flight
            if ((state_reg == ST_FIT_MUL_A) || (state_reg == ST_FIT_MUL_B) ||
                (state_reg == ST_FIT_DIV))
            begin
                state_next = ST_IDLE;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            dirty_reg      <= 1'b1;
            out_valid_reg  <= 1'b0;
            src_width_reg  <= nnis_pkg::SRC_DIM_RESET;
            src_height_reg <= nnis_pkg::SRC_DIM_RESET;
            box_width_reg  <= nnis_pkg::BOX_DIM_RESET;
            box_height_reg <= nnis_pkg::BOX_DIM_RESET;
        end
        else
        begin
            state_reg     <= state_next;
            dirty_reg     <= dirty_next;
            out_valid_reg <= out_valid_next;
            if (cfg_write)
            begin
                unique case (cfg_index)
                    nnis_pkg::CFG_SRC_WIDTH:  src_width_reg  <= cfg_data[SRC_W-1:0];
                    nnis_pkg::CFG_SRC_HEIGHT: src_height_reg <= cfg_data[SRC_W-1:0];
                    nnis_pkg::CFG_BOX_WIDTH:  box_width_reg  <= cfg_data[BOX_W-1:0];
                    nnis_pkg::CFG_BOX_HEIGHT: box_height_reg <= cfg_data[BOX_W-1:0];
                    default:
                    begin
                    end
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        ow_reg       <= ow_next;
        oh_reg       <= oh_next;
        pa_reg       <= pa_next;
        fit_h_reg    <= fit_h_next;
        sx_reg       <= sx_next;
        pix_reg      <= pix_next;
        flag_reg     <= flag_next;
        out_pix_reg  <= out_pix_next;
        out_flag_reg <= out_flag_next;
        if (accept)
        begin
            req_type_reg       <= request.req_type;
            px_reg             <= request.pos_x;
            py_reg             <= request.pos_y;
            load_pix_reg.hue   <= request.in_hue;
            load_pix_reg.sat   <= request.in_sat;
            load_pix_reg.lum   <= request.in_lum;
            load_pix_reg.alpha <= request.in_alpha;
        end
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            frame_store[mem_addr] <= load_pix_reg;
        end
        if (mem_re)
        begin
            mem_q_reg <= frame_store[mem_addr];
        end
    end

    assign result.valid        = out_valid_reg;
    assign result.out_hue      = out_pix_reg.hue;
    assign result.out_sat      = out_pix_reg.sat;
    assign result.out_lum      = out_pix_reg.lum;
    assign result.out_alpha    = out_pix_reg.alpha;
    assign result.out_width    = ow_reg;
    assign result.out_height   = oh_reg;
    assign result.out_of_range = out_flag_reg;

endmodule

/* bench/tb.sv */
module tb;

    localparam int MAX_SRC = 256;
    localparam int MAX_OUT = 4096;
    localparam int SETTLE_CYCLES = 100;

    typedef struct {
        nnis_pkg::req_type_t                kind;
        logic [nnis_pkg::POS_W-1:0]        x;
        logic [nnis_pkg::POS_W-1:0]        y;
        nnis_pkg::pixel_t                  pix;
    } pixel_request_t;

    typedef struct {
        nnis_pkg::pixel_t                  pix;
        logic [nnis_pkg::BOX_DIM_W-1:0]    width;
        logic [nnis_pkg::BOX_DIM_W-1:0]    height;
        logic                              flag;
    } scaled_pixel_t;

    class pixel_ledger;
        logic [nnis_pkg::SRC_DIM_W-1:0] src_w_reg;
        logic [nnis_pkg::SRC_DIM_W-1:0] src_h_reg;
        logic [nnis_pkg::BOX_DIM_W-1:0] box_w_reg;
        logic [nnis_pkg::BOX_DIM_W-1:0] box_h_reg;
        nnis_pkg::pixel_t               frame[int];
        scaled_pixel_t                  awaited_pixels[$];
        int                             mismatches;

        function new();
            src_w_reg = nnis_pkg::SRC_DIM_RESET;
            src_h_reg = nnis_pkg::SRC_DIM_RESET;
            box_w_reg = nnis_pkg::BOX_DIM_RESET;
            box_h_reg = nnis_pkg::BOX_DIM_RESET;
            mismatches = 0;
        endfunction

        function void write_config(nnis_pkg::cfg_index_t idx,
                                   logic [nnis_pkg::CFG_DATA_W-1:0] data);
            case (idx)
                nnis_pkg::CFG_SRC_WIDTH:  src_w_reg = data[nnis_pkg::SRC_DIM_W-1:0];
                nnis_pkg::CFG_SRC_HEIGHT: src_h_reg = data[nnis_pkg::SRC_DIM_W-1:0];
                nnis_pkg::CFG_BOX_WIDTH:  box_w_reg = data[nnis_pkg::BOX_DIM_W-1:0];
                nnis_pkg::CFG_BOX_HEIGHT: box_h_reg = data[nnis_pkg::BOX_DIM_W-1:0];
                default: ;
            endcase
        endfunction

        function int clamp_dim(int v, int hi);
            if (v == 0)
                return 1;
            if (v > hi)
                return hi;
            return v;
        endfunction

        function int src_w();
            return clamp_dim(int'(src_w_reg), MAX_SRC);
        endfunction

        function int src_h();
            return clamp_dim(int'(src_h_reg), MAX_SRC);
        endfunction

        function void fit(output int ow, output int oh);
            int sw;
            int sh;
            int bw;
            int bh;
            sw = src_w();
            sh = src_h();
            bw = clamp_dim(int'(box_w_reg), MAX_OUT);
            bh = clamp_dim(int'(box_h_reg), MAX_OUT);
            if (sh * bw > bh * sw)
            begin
                ow = (bh * sw) / sh;
                oh = bh;
            end
            else
            begin
                ow = bw;
                oh = (bw * sh) / sw;
            end
            if (ow == 0)
                ow = 1;
            if (oh == 0)
                oh = 1;
        endfunction

        function int source_index(int ox, int oy);
            int ow;
            int oh;
            fit(ow, oh);
            return (ox * src_w()) / ow + ((oy * src_h()) / oh) * src_w();
        endfunction

        function bit entry_loaded(int idx);
            return frame.exists(idx);
        endfunction

        function int awaited_count();
            return awaited_pixels.size();
        endfunction

        function void log_request(pixel_request_t r);
            int sw;
            int sh;
            int ow;
            int oh;
            int idx;
            scaled_pixel_t res;
            sw = src_w();
            sh = src_h();
            fit(ow, oh);
            res.pix = '0;
            res.width = ow[nnis_pkg::BOX_DIM_W-1:0];
            res.height = oh[nnis_pkg::BOX_DIM_W-1:0];
            res.flag = 1'b0;
            if (r.kind == nnis_pkg::REQ_LOAD)
            begin
                if (int'(r.x) < sw && int'(r.y) < sh)
                begin
                    frame[int'(r.x) + int'(r.y) * sw] = r.pix;
                    return;
                end
                res.flag = 1'b1;
            end
            else if (int'(r.x) < ow && int'(r.y) < oh)
            begin
                idx = source_index(int'(r.x), int'(r.y));
                if (frame.exists(idx))
                    res.pix = frame[idx];
            end
            else
            begin
                res.flag = 1'b1;
            end
            awaited_pixels.push_back(res);
        endfunction

        function void compare_field(string name, logic [15:0] want, logic [15:0] got);
            if (got !== want)
            begin
                $error("%s expected %0d actual %0d", name, want, got);
                mismatches++;
            end
        endfunction

        function void match_result(scaled_pixel_t got);
            scaled_pixel_t want;
            if (awaited_pixels.size() == 0)
            begin
                $error("result with no request outstanding");
                mismatches++;
                return;
            end
            want = awaited_pixels.pop_front();
            compare_field("out_hue", want.pix.hue, got.pix.hue);
            compare_field("out_sat", want.pix.sat, got.pix.sat);
            compare_field("out_lum", want.pix.lum, got.pix.lum);
            compare_field("out_alpha", want.pix.alpha, got.pix.alpha);
            compare_field("out_width", 16'(want.width), 16'(got.width));
            compare_field("out_height", 16'(want.height), 16'(got.height));
            compare_field("out_of_range", 16'(want.flag), 16'(got.flag));
        endfunction
    endclass

    logic                             clk;
    logic                             rst_n;
    logic                             cfg_write;
    logic [nnis_pkg::CFG_INDEX_W-1:0] cfg_index;
    logic [nnis_pkg::CFG_DATA_W-1:0]  cfg_data;

    nnis_req_if req_ch ();
    nnis_rsp_if rsp_ch ();

    pixel_ledger book = new();
    int          sent;

    nearest_neighbor_image_scaler dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .request   (req_ch),
        .result    (rsp_ch),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always #1 clk = ~clk;

    function nnis_pkg::pixel_t random_pixel();
        nnis_pkg::pixel_t p;
        if ($urandom_range(1) == 0)
        begin
            p.hue   = 16'($urandom_range(46080));
            p.sat   = 16'($urandom_range(32768));
            p.lum   = 16'($urandom_range(32768));
            p.alpha = 16'($urandom_range(32768));
        end
        else
        begin
            p = {$urandom, $urandom};
        end
        return p;
    endfunction

    task automatic send_request(pixel_request_t r);
        if (!(sent >= 800 && sent < 1100) && $urandom_range(99) < 9)
        begin
            repeat ($urandom_range(6, 1))
            begin
                @(negedge clk);
                req_ch.valid = 1'b0;
            end
        end
        @(negedge clk);
        req_ch.valid    = 1'b1;
        req_ch.req_type = r.kind;
        req_ch.pos_x    = r.x;
        req_ch.pos_y    = r.y;
        req_ch.in_hue   = r.pix.hue;
        req_ch.in_sat   = r.pix.sat;
        req_ch.in_lum   = r.pix.lum;
        req_ch.in_alpha = r.pix.alpha;
        do
            @(posedge clk);
        while (req_ch.ready !== 1'b1);
        book.log_request(r);
        sent++;
    endtask

    task automatic send_load(int x, int y, nnis_pkg::pixel_t pix);
        pixel_request_t r;
        r.kind = nnis_pkg::REQ_LOAD;
        r.x = x[nnis_pkg::POS_W-1:0];
        r.y = y[nnis_pkg::POS_W-1:0];
        r.pix = pix;
        send_request(r);
    endtask

    // load the selected entry first when it has never been written
    task automatic send_read(int x, int y);
        pixel_request_t r;
        int ow;
        int oh;
        int sw;
        int idx;
        book.fit(ow, oh);
        sw = book.src_w();
        if (x < ow && y < oh)
        begin
            idx = book.source_index(x, y);
            if (!book.entry_loaded(idx))
                send_load(idx % sw, idx / sw, random_pixel());
        end
        r.kind = nnis_pkg::REQ_READ;
        r.x = x[nnis_pkg::POS_W-1:0];
        r.y = y[nnis_pkg::POS_W-1:0];
        r.pix = random_pixel();
        send_request(r);
    endtask

    task automatic write_reg(nnis_pkg::cfg_index_t idx, int value);
        @(negedge clk);
        cfg_write = 1'b1;
        cfg_index = idx;
        cfg_data  = value[nnis_pkg::CFG_DATA_W-1:0];
        book.write_config(idx, value[nnis_pkg::CFG_DATA_W-1:0]);
        @(negedge clk);
        cfg_write = 1'b0;
    endtask

    task automatic settle();
        @(negedge clk);
        req_ch.valid = 1'b0;
        while (book.awaited_count() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic run_random(int count);
        int sw;
        int sh;
        int ow;
        int oh;
        int x;
        int y;
        int pick;
        for (int k = 0; k < count; k++)
        begin
            sw = book.src_w();
            sh = book.src_h();
            book.fit(ow, oh);
            pick = $urandom_range(99);
            if (pick < 35)
            begin
                send_load($urandom_range(sw - 1), $urandom_range(sh - 1), random_pixel());
            end
            else if (pick < 80)
            begin
                x = $urandom_range(ow - 1);
                y = $urandom_range(oh - 1);
                if ($urandom_range(9) == 0)
                    x = ow - 1;
                if ($urandom_range(9) == 0)
                    y = oh - 1;
                send_read(x, y);
            end
            else if (pick < 92)
            begin
                send_read($urandom_range(4095), $urandom_range(4095));
            end
            else if ($urandom_range(1) == 0)
            begin
                send_load(sw + $urandom_range(4095 - sw), $urandom_range(4095), random_pixel());
            end
            else
            begin
                send_load($urandom_range(4095), sh + $urandom_range(4095 - sh), random_pixel());
            end
        end
    endtask

    initial
    begin
        int presets [6][4];
        int vals [4];
        presets = '{
            '{0, 0, 0, 0},
            '{511, 511, 8191, 8191},
            '{256, 1, 1, 4096},
            '{1, 256, 4096, 1},
            '{3, 5, 4096, 4096},
            '{7, 2, 13, 40}
        };
        clk = 1'b0;
        rst_n = 1'b0;
        cfg_write = 1'b0;
        cfg_index = nnis_pkg::CFG_SRC_WIDTH;
        cfg_data = '0;
        req_ch.valid = 1'b0;
        req_ch.req_type = nnis_pkg::REQ_LOAD;
        req_ch.pos_x = '0;
        req_ch.pos_y = '0;
        req_ch.in_hue = '0;
        req_ch.in_sat = '0;
        req_ch.in_lum = '0;
        req_ch.in_alpha = '0;
        sent = 0;
        repeat (4) @(negedge clk);
        rst_n = 1'b1;

        send_load(0, 0, {16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF});
        send_load(255, 255, '0);
        send_load(255, 0, {16'd46080, 16'd32768, 16'd32768, 16'd32768});
        send_load(0, 255, {16'h1234, 16'h5678, 16'h9ABC, 16'hDEF0});
        send_load(256, 0, {16'hAAAA, 16'h5555, 16'hAAAA, 16'h5555});
        send_load(0, 256, {16'h5555, 16'hAAAA, 16'h5555, 16'hAAAA});
        send_load(4095, 4095, {16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF});
        send_read(0, 0);
        send_read(255, 255);
        send_read(255, 0);
        send_read(0, 255);
        send_read(256, 0);
        send_read(0, 256);
        send_read(4095, 4095);
        send_read(4095, 0);

        for (int p = 0; p < 22; p++)
        begin
            settle();
            if (p < 6)
            begin
                vals = presets[p];
            end
            else
            begin
                vals[0] = ($urandom_range(9) < 7) ? $urandom_range(12, 1) : $urandom_range(8191);
                vals[1] = ($urandom_range(9) < 7) ? $urandom_range(12, 1) : $urandom_range(8191);
                vals[2] = ($urandom_range(1) == 0) ? $urandom_range(64, 1) : $urandom_range(8191);
                vals[3] = ($urandom_range(1) == 0) ? $urandom_range(64, 1) : $urandom_range(8191);
            end
            write_reg(nnis_pkg::CFG_SRC_WIDTH, vals[0]);
            write_reg(nnis_pkg::CFG_SRC_HEIGHT, vals[1]);
            write_reg(nnis_pkg::CFG_BOX_WIDTH, vals[2]);
            write_reg(nnis_pkg::CFG_BOX_HEIGHT, vals[3]);
            run_random((p < 6) ? 50 : 80);
        end

        settle();
        repeat (200) @(posedge clk);
        if (book.mismatches == 0 && book.awaited_count() == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

    // result side: random back-pressure, one long hold-off, one steady stretch
    initial
    begin
        int            got;
        bit            held;
        scaled_pixel_t seen;
        got = 0;
        held = 1'b0;
        rsp_ch.ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (!held && got >= 300)
            begin
                held = 1'b1;
                rsp_ch.ready = 1'b0;
                repeat (1500) @(negedge clk);
            end
            rsp_ch.ready = (got >= 800 && got < 1100) || ($urandom_range(99) >= 9);
            @(posedge clk);
            if (rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1)
            begin
                seen.pix.hue   = rsp_ch.out_hue;
                seen.pix.sat   = rsp_ch.out_sat;
                seen.pix.lum   = rsp_ch.out_lum;
                seen.pix.alpha = rsp_ch.out_alpha;
                seen.width     = rsp_ch.out_width;
                seen.height    = rsp_ch.out_height;
                seen.flag      = rsp_ch.out_of_range;
                book.match_result(seen);
                got++;
            end
        end
    end

    initial
    begin
        #6000000;
        $display("Test completed with failures");
        $finish;
    end
endmodule

/* sim.f */
design/nnis_pkg.sv
design/nnis_if.sv
design/nnis_mul.sv
design/nnis_div.sv
design/nearest_neighbor_image_scaler.sv
bench/tb.sv
